### rtl/core/rcm_pkg.sv
// rcm_pkg: shared types and constants of the rms current meter
// used by every file under rtl/core, depends on nothing
package rcm_pkg;

   localparam int DEF_SAMPLE_BITS = 12;
   localparam int DEF_MAX_WINDOW  = 1024;

   localparam int WIN_BITS    = 11;
   localparam int GAIN_BITS   = 16;
   localparam int SHIFT_BITS  = 4;
   localparam int OUT_BITS    = 17;
   localparam int SUM_BITS    = 43;
   localparam int CSR_BITS    = 2;
   localparam int WDATA_BITS  = 16;

   localparam int OFFSET_FRAC = 12;
   localparam int CENTER_FRAC = 4;
   localparam int DROP_BITS   = OFFSET_FRAC - CENTER_FRAC;
   localparam int SQ_SCALE    = 2 * CENTER_FRAC;
   localparam int GAIN_FRAC   = 16;

   localparam int RAD_BITS    = SUM_BITS + SQ_SCALE + ((SUM_BITS + SQ_SCALE) % 2);
   localparam int ROOT_BITS   = RAD_BITS / 2;
   localparam int PROD_BITS   = GAIN_BITS + ROOT_BITS;
   localparam int ITER_BITS   = $clog2(SUM_BITS);

   localparam int QUEUE_DEPTH = 2;
   localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);
   localparam int FILL_BITS   = $clog2(QUEUE_DEPTH + 1);

   localparam logic [WIN_BITS-1:0]   WINDOW_RESET = WIN_BITS'(50);
   localparam logic [GAIN_BITS-1:0]  GAIN_RESET   = GAIN_BITS'(4125);
   localparam logic [SHIFT_BITS-1:0] SHIFT_RESET  = SHIFT_BITS'(12);
   localparam logic [OUT_BITS-1:0]   OUT_MAX      = {OUT_BITS{1'b1}};

   typedef enum logic [CSR_BITS-1:0] {
      CSR_WINDOW = 2'd0,
      CSR_GAIN   = 2'd1,
      CSR_SHIFT  = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [SUM_BITS-1:0]  sum;
      logic [WIN_BITS-1:0]  win;
      logic [GAIN_BITS-1:0] gain;
   } job_type;

endpackage

### rtl/core/rcm_front.sv
// rcm_front: offset tracking, centering, squaring and window accumulation
// depends on rcm_pkg, hands finished windows to rcm_queue
module rcm_front #(
   parameter int SAMPLE_BITS = rcm_pkg::DEF_SAMPLE_BITS,
   parameter int MAX_WINDOW  = rcm_pkg::DEF_MAX_WINDOW
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [SAMPLE_BITS-1:0]           req_sample,
   input  logic [rcm_pkg::WIN_BITS-1:0]     window_length_i,
   input  logic [rcm_pkg::GAIN_BITS-1:0]    milliamp_gain_i,
   input  logic [rcm_pkg::SHIFT_BITS-1:0]   offset_shift_i,
   output logic                             push_o,
   output rcm_pkg::job_type                 push_job_o,
   input  logic                             full_i
);

   localparam int OFF_BITS = SAMPLE_BITS + rcm_pkg::OFFSET_FRAC;
   localparam int DW       = OFF_BITS + 2;
   localparam int MAG_BITS = SAMPLE_BITS + rcm_pkg::CENTER_FRAC;
   localparam int SQ_BITS  = 2 * MAG_BITS;
   localparam int WB       = rcm_pkg::WIN_BITS;
   localparam int SB       = rcm_pkg::SUM_BITS;
   localparam logic [OFF_BITS-1:0] OFF_RESET = OFF_BITS'(1) << (OFF_BITS - 1);
   localparam logic signed [DW-1:0] ROUND_HALF = DW'(1) << (rcm_pkg::DROP_BITS - 1);

   typedef enum logic [1:0] {
      F_IDLE,
      F_CENTER,
      F_SQUARE,
      F_ACCUM
   } fstate_type;

   fstate_type              state_ff, state_in;
   logic [SAMPLE_BITS-1:0]  sample_ff, sample_in;
   logic [OFF_BITS-1:0]     offset_ff, offset_in;
   logic [MAG_BITS-1:0]     mag_ff, mag_in;
   logic [SQ_BITS-1:0]      sq_ff, sq_in;
   logic [SB-1:0]           sum_ff, sum_in;
   logic [WB-1:0]           count_ff, count_in;

   logic [OFF_BITS-1:0]     target;
   logic signed [DW-1:0]    diff, step, new_off, cdiff, centered;
   logic [SB-1:0]           sum_next;
   logic [WB-1:0]           count_next;
   logic [WB-1:0]           win;
   logic                    window_done;

   assign req_stall = (state_ff != F_IDLE);

   always_comb begin
      if (window_length_i == '0) begin
         win = WB'(1);
      end else if (32'(window_length_i) > MAX_WINDOW) begin
         win = WB'(MAX_WINDOW);
      end else begin
         win = window_length_i;
      end
   end

   always_comb begin
      target   = OFF_BITS'(sample_ff) << rcm_pkg::OFFSET_FRAC;
      diff     = $signed(DW'(target)) - $signed(DW'(offset_ff));
      step     = diff >>> offset_shift_i;
      new_off  = $signed(DW'(offset_ff)) + step;
      cdiff    = $signed(DW'(target)) - new_off + ROUND_HALF;
      centered = cdiff >>> rcm_pkg::DROP_BITS;
   end

   assign sum_next    = sum_ff + SB'(sq_ff);
   assign count_next  = count_ff + WB'(1);
   assign window_done = (count_next >= win);

   always_comb begin
      state_in   = state_ff;
      sample_in  = sample_ff;
      offset_in  = offset_ff;
      mag_in     = mag_ff;
      sq_in      = sq_ff;
      sum_in     = sum_ff;
      count_in   = count_ff;
      push_o     = 1'b0;
      push_job_o = '{sum: sum_next, win: win, gain: milliamp_gain_i};
      unique case (state_ff)
         F_IDLE: begin
            if (req_valid) begin
               sample_in = req_sample;
               state_in  = F_CENTER;
            end
         end
         F_CENTER: begin
            offset_in = new_off[OFF_BITS-1:0];
            if (centered < 0) begin
               mag_in = MAG_BITS'(-centered);
            end else begin
               mag_in = MAG_BITS'(centered);
            end
            state_in = F_SQUARE;
         end
         F_SQUARE: begin
            sq_in    = SQ_BITS'(mag_ff) * SQ_BITS'(mag_ff);
            state_in = F_ACCUM;
         end
         F_ACCUM: begin
            if (!window_done) begin
               sum_in   = sum_next;
               count_in = count_next;
               state_in = F_IDLE;
            end else if (!full_i) begin
               push_o   = 1'b1;
               sum_in   = '0;
               count_in = '0;
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= F_IDLE;
         offset_ff <= OFF_RESET;
         sum_ff    <= '0;
         count_ff  <= '0;
      end else begin
         state_ff  <= state_in;
         offset_ff <= offset_in;
         sum_ff    <= sum_in;
         count_ff  <= count_in;
      end
      sample_ff <= sample_in;
      mag_ff    <= mag_in;
      sq_ff     <= sq_in;
   end

endmodule

### rtl/core/rcm_queue.sv
// rcm_queue: short fifo of finished windows between front and back
// depends on rcm_pkg
module rcm_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_i,
   input  rcm_pkg::job_type push_job_i,
   output logic             full_o,
   input  logic             pop_i,
   output rcm_pkg::job_type pop_job_o,
   output logic             empty_o
);

   localparam int DEPTH = rcm_pkg::QUEUE_DEPTH;
   localparam int PB    = rcm_pkg::PTR_BITS;
   localparam int FB    = rcm_pkg::FILL_BITS;

   rcm_pkg::job_type entry_ff [DEPTH];
   logic [PB-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PB-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [FB-1:0]    fill_ff, fill_in;

   assign full_o    = (fill_ff == FB'(DEPTH));
   assign empty_o   = (fill_ff == '0);
   assign pop_job_o = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push_i) begin
         wr_ptr_in = (wr_ptr_ff == PB'(DEPTH - 1)) ? '0 : wr_ptr_ff + PB'(1);
      end
      if (pop_i) begin
         rd_ptr_in = (rd_ptr_ff == PB'(DEPTH - 1)) ? '0 : rd_ptr_ff + PB'(1);
      end
      if (push_i && !pop_i) begin
         fill_in = fill_ff + FB'(1);
      end else if (pop_i && !push_i) begin
         fill_in = fill_ff - FB'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      if (push_i) begin
         entry_ff[wr_ptr_ff] <= push_job_i;
      end
   end

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push_i |-> !full_o) else $error("push into full queue");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop_i |-> !empty_o) else $error("pop from empty queue");
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FB'(DEPTH)) else $error("queue fill out of range");
   a_push_lands: assert property (@(posedge clock) disable iff (reset)
      (push_i && !pop_i) |=> !empty_o) else $error("pushed window lost");

endmodule

### rtl/core/rcm_back.sv
// rcm_back: per-window divide, square root, gain scaling and result register
// depends on rcm_pkg, takes windows from rcm_queue
module rcm_back (
   input  logic                           clock,
   input  logic                           reset,
   output logic                           pop_o,
   input  rcm_pkg::job_type               pop_job_i,
   input  logic                           empty_i,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [rcm_pkg::OUT_BITS-1:0]   rsp_rms_milliamps
);

   localparam int SB = rcm_pkg::SUM_BITS;
   localparam int WB = rcm_pkg::WIN_BITS;
   localparam int GB = rcm_pkg::GAIN_BITS;
   localparam int RB = rcm_pkg::RAD_BITS;
   localparam int QB = rcm_pkg::ROOT_BITS;
   localparam int PB = rcm_pkg::PROD_BITS;
   localparam int IB = rcm_pkg::ITER_BITS;
   localparam int OB = rcm_pkg::OUT_BITS;
   localparam logic [PB:0] ROUND_ADD = (PB + 1)'(1) << (rcm_pkg::GAIN_FRAC - 1);

   typedef enum logic [2:0] {
      B_IDLE,
      B_DIV,
      B_ROOT_LOAD,
      B_ROOT,
      B_MUL,
      B_OUT
   } bstate_type;

   bstate_type       state_ff;
   logic [SB-1:0]    quo_ff;
   logic [WB-1:0]    rem_ff;
   logic [WB-1:0]    win_ff;
   logic [GB-1:0]    gain_ff;
   logic [IB-1:0]    iter_ff;
   logic [RB-1:0]    rad_ff;
   logic [QB-1:0]    root_ff;
   logic [QB+1:0]    srem_ff;
   logic [PB-1:0]    prod_ff;
   logic             rsp_valid_ff;
   logic [OB-1:0]    rsp_data_ff;

   logic [WB:0]      rem_sh;
   logic             div_take;
   logic [QB+3:0]    srem_sh;
   logic [QB+3:0]    trial;
   logic             root_take;
   logic [PB:0]      rounded_wide;
   logic [PB:0]      scaled;
   logic [OB-1:0]    result;
   logic             out_free;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_rms_milliamps = rsp_data_ff;
   assign pop_o             = (state_ff == B_IDLE) && !empty_i;
   assign out_free          = !rsp_valid_ff || !rsp_stall;

   assign rem_sh   = {rem_ff, quo_ff[SB-1]};
   assign div_take = (rem_sh >= {1'b0, win_ff});

   assign srem_sh   = {srem_ff, rad_ff[RB-1 -: 2]};
   assign trial     = {2'b00, root_ff, 2'b01};
   assign root_take = (srem_sh >= trial);

   assign rounded_wide = {1'b0, prod_ff} + ROUND_ADD;
   assign scaled       = rounded_wide >> rcm_pkg::GAIN_FRAC;
   assign result       = (scaled > (PB + 1)'(rcm_pkg::OUT_MAX)) ? rcm_pkg::OUT_MAX
                                                               : OB'(scaled);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && (state_ff != B_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            B_IDLE: begin
               if (!empty_i) begin
                  quo_ff   <= pop_job_i.sum;
                  win_ff   <= pop_job_i.win;
                  gain_ff  <= pop_job_i.gain;
                  rem_ff   <= '0;
                  iter_ff  <= IB'(SB - 1);
                  state_ff <= B_DIV;
               end
            end
            B_DIV: begin
               rem_ff  <= div_take ? WB'(rem_sh - {1'b0, win_ff}) : rem_sh[WB-1:0];
               quo_ff  <= {quo_ff[SB-2:0], div_take};
               iter_ff <= iter_ff - IB'(1);
               if (iter_ff == '0) begin
                  state_ff <= B_ROOT_LOAD;
               end
            end
            B_ROOT_LOAD: begin
               rad_ff   <= RB'({quo_ff, {rcm_pkg::SQ_SCALE{1'b0}}});
               root_ff  <= '0;
               srem_ff  <= '0;
               iter_ff  <= IB'(QB - 1);
               state_ff <= B_ROOT;
            end
            B_ROOT: begin
               srem_ff <= root_take ? (QB + 2)'(srem_sh - trial) : srem_sh[QB+1:0];
               root_ff <= {root_ff[QB-2:0], root_take};
               rad_ff  <= rad_ff << 2;
               iter_ff <= iter_ff - IB'(1);
               if (iter_ff == '0) begin
                  state_ff <= B_MUL;
               end
            end
            B_MUL: begin
               prod_ff  <= PB'(gain_ff) * PB'(root_ff);
               state_ff <= B_OUT;
            end
            B_OUT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= result;
                  state_ff     <= B_IDLE;
               end
            end
            default: state_ff <= B_IDLE;
         endcase
      end
   end

endmodule

### rtl/core/rms_current_meter_top.sv
// rms_current_meter_top: true rms current meter with dc offset tracking
// depends on rcm_pkg, rcm_front, rcm_queue, rcm_back
//
//   channel | direction | handshake             | payload
//   req     | in        | req_valid / req_stall | req_sample
//   rsp     | out       | rsp_valid / rsp_stall | rsp_rms_milliamps
//   csr     | in        | csr_valid / csr_ready | csr_index, csr_wdata
//
// a sample passes the front sequencer: capture, offset update, square, accumulate
// a window result passes the back unit's one-bit-per-cycle divider, then the
// two-bit-per-cycle square root, the gain multiply and the output register
// the back unit runs while the front fills the next window, a 2-entry queue sits between
// synchronous reset restores states, csr values, offset, sums and queue pointers, no clearing pass is needed
// a stalled result holds in the output register, beyond its own per-sample sequence
// the front stalls only when the queue is full
module rms_current_meter_top #(
   parameter int SAMPLE_BITS = rcm_pkg::DEF_SAMPLE_BITS,
   parameter int MAX_WINDOW  = rcm_pkg::DEF_MAX_WINDOW
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [SAMPLE_BITS-1:0]            req_sample,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [rcm_pkg::OUT_BITS-1:0]      rsp_rms_milliamps,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [rcm_pkg::CSR_BITS-1:0]      csr_index,
   input  logic [rcm_pkg::WDATA_BITS-1:0]    csr_wdata
);

   logic [rcm_pkg::WIN_BITS-1:0]   window_length_ff;
   logic [rcm_pkg::GAIN_BITS-1:0]  milliamp_gain_ff;
   logic [rcm_pkg::SHIFT_BITS-1:0] offset_shift_ff;

   logic             push;
   rcm_pkg::job_type push_job;
   logic             full;
   logic             pop;
   rcm_pkg::job_type pop_job;
   logic             empty;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_length_ff <= rcm_pkg::WINDOW_RESET;
         milliamp_gain_ff <= rcm_pkg::GAIN_RESET;
         offset_shift_ff  <= rcm_pkg::SHIFT_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (rcm_pkg::csr_index_type'(csr_index))
            rcm_pkg::CSR_WINDOW: window_length_ff <= csr_wdata[rcm_pkg::WIN_BITS-1:0];
            rcm_pkg::CSR_GAIN:   milliamp_gain_ff <= csr_wdata[rcm_pkg::GAIN_BITS-1:0];
            rcm_pkg::CSR_SHIFT:  offset_shift_ff  <= csr_wdata[rcm_pkg::SHIFT_BITS-1:0];
            default: ;
         endcase
      end
   end

   rcm_front #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .MAX_WINDOW  (MAX_WINDOW)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_sample      (req_sample),
      .window_length_i (window_length_ff),
      .milliamp_gain_i (milliamp_gain_ff),
      .offset_shift_i  (offset_shift_ff),
      .push_o          (push),
      .push_job_o      (push_job),
      .full_i          (full)
   );

   rcm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_i     (push),
      .push_job_i (push_job),
      .full_o     (full),
      .pop_i      (pop),
      .pop_job_o  (pop_job),
      .empty_o    (empty)
   );

   rcm_back u_back (
      .clock             (clock),
      .reset             (reset),
      .pop_o             (pop),
      .pop_job_i         (pop_job),
      .empty_i           (empty),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_rms_milliamps (rsp_rms_milliamps)
   );

endmodule
